/* hdl/lgts_pkg.sv */
// Shared constants and helpers for the labeled LDA Gibbs topic sampler.
// No dependencies.
`default_nettype none
package lgts_pkg;

    localparam int DEF_MAX_TOPICS  = 32;
    localparam int DEF_MAX_CLASSES = 8;
    localparam int DEF_MAX_VOCAB   = 1024;
    localparam int DEF_MAX_DOCS    = 1024;
    localparam int DEF_MAX_TOKENS  = 65536;

    localparam int CNT_W  = 16;
    localparam int FRAC_W = 16;
    localparam int TOPIC_OUT_W = 5;

    localparam logic [1:0] REG_NUM_TOPICS = 2'd0;
    localparam logic [1:0] REG_VOCAB_SIZE = 2'd1;
    localparam logic [1:0] REG_ALPHA      = 2'd2;
    localparam logic [1:0] REG_BETA       = 2'd3;

    localparam logic [5:0]  RST_NUM_TOPICS = 6'd8;
    localparam logic [10:0] RST_VOCAB_SIZE = 11'd1024;
    localparam logic [23:0] RST_ALPHA      = 24'd32768;
    localparam logic [23:0] RST_BETA       = 24'd6554;

    // x mod m for a constant m: the rounded-up reciprocal 2^48/m gives an
    // exact quotient for any 16-bit x.
    function automatic logic [15:0] mod_const(input logic [15:0] x, input int m);
        logic [63:0] recip;
        logic [63:0] quo;
        begin
            recip     = ((64'd1 << 48) + 64'(m) - 64'd1) / 64'(m);
            quo       = (64'(x) * recip) >> 48;
            mod_const = 16'(64'(x) - quo * 64'(m));
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/lgts_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module lgts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                      wdata,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

/* hdl/labeled_lda_gibbs_topic_sampler_core.sv */
// Top level of the labeled LDA collapsed Gibbs topic sampler.
// Depends on lgts_pkg and lgts_ram.
`default_nettype none
// Usage:
//  - Command channel: an item is taken when start is high and busy is low.
//    Fields: action (0 init, 1 resample), token_index, doc_index,
//    class_index, term_id, random_value.
//  - Result: topic is shown for exactly one cycle with done high. The
//    receiver cannot stall; the block takes the next item in that cycle.
//  - Config: cfg_valid/cfg_ready write port, cfg_ready always high. Write
//    only while busy is low and no result is pending.
//  - Sequence: an index wrap state, then init writes the token topic and
//    increments its counts (S_IRD, S_IWR); done is high in the cycle after
//    S_IWR. Resample decrements the old topic's counts, then per topic reads
//    counts, runs a 2-bit-per-cycle divider unless its ratio saturates or its
//    denominator is zero and accumulates a prefix; the search reads one prefix
//    per cycle, then S_IRD, S_IWR. No new item is taken until done.
//  - Reset: after rst_n rises, a clearing pass zeroes the count memories;
//    busy stays high meanwhile. Config writes are taken anyway.
//  - State lives in single-port RAMs: word/class/topic, class/topic,
//    doc/topic counts, token topics and the prefix weights.
module labeled_lda_gibbs_topic_sampler_core #(
    parameter int MAX_TOPICS  = lgts_pkg::DEF_MAX_TOPICS,
    parameter int MAX_CLASSES = lgts_pkg::DEF_MAX_CLASSES,
    parameter int MAX_VOCAB   = lgts_pkg::DEF_MAX_VOCAB,
    parameter int MAX_DOCS    = lgts_pkg::DEF_MAX_DOCS,
    parameter int MAX_TOKENS  = lgts_pkg::DEF_MAX_TOKENS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        action,
    input  wire logic [15:0] token_index,
    input  wire logic [9:0]  doc_index,
    input  wire logic [2:0]  class_index,
    input  wire logic [9:0]  term_id,
    input  wire logic [15:0] random_value,
    output logic             done,
    output logic [4:0]       topic,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int TW      = $clog2(MAX_TOPICS);
    localparam int KW      = $clog2(MAX_TOPICS + 1);
    localparam int WCT_D   = MAX_VOCAB * MAX_CLASSES * MAX_TOPICS;
    localparam int CT_D    = MAX_CLASSES * MAX_TOPICS;
    localparam int DT_D    = MAX_DOCS * MAX_TOPICS;
    localparam int WCT_AW  = $clog2(WCT_D);
    localparam int CT_AW   = $clog2(CT_D);
    localparam int DT_AW   = $clog2(DT_D);
    localparam int TOK_AW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int CLR_D   = (WCT_D > DT_D) ? WCT_D : DT_D;
    localparam int CLW     = $clog2(CLR_D);
    localparam int CW      = lgts_pkg::CNT_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RED   = 4'd2;
    localparam logic [3:0] S_TRD   = 4'd3;
    localparam logic [3:0] S_DRD   = 4'd4;
    localparam logic [3:0] S_DWR   = 4'd5;
    localparam logic [3:0] S_LRD   = 4'd6;
    localparam logic [3:0] S_LCALC = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_TGT   = 4'd11;
    localparam logic [3:0] S_SRD   = 4'd12;
    localparam logic [3:0] S_SCMP  = 4'd13;
    localparam logic [3:0] S_IRD   = 4'd14;
    localparam logic [3:0] S_IWR   = 4'd15;

    logic [3:0]  state_reg, state_next;
    logic [CLW-1:0] clr_reg, clr_next;

    logic [5:0]  num_topics_reg;
    logic [10:0] vocab_size_reg;
    logic [23:0] alpha_reg, beta_reg;

    logic        act_reg, act_next;
    logic [15:0] tok_reg, tok_next;
    logic [15:0] doc_reg, doc_next;
    logic [15:0] cls_reg, cls_next;
    logic [15:0] term_reg, term_next;
    logic [15:0] r_reg, r_next;
    logic [KW-1:0] k_reg, k_next;
    logic [34:0] bw_reg, bw_next;
    logic [3:0]  step_reg, step_next;

    logic [WCT_AW-1:0] wbase_reg, wbase_next;
    logic [CT_AW-1:0]  cbase_reg, cbase_next;
    logic [DT_AW-1:0]  dbase_reg, dbase_next;

    logic [TW-1:0] old_reg, old_next;
    logic [TW-1:0] topic_reg, topic_next;
    logic [KW-1:0] z_reg, z_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   tgt_reg, tgt_next;

    logic [35:0] den_reg, den_next;
    logic [32:0] dsm_reg, dsm_next;
    logic [35:0] rem_reg, rem_next;
    logic [23:0] dvd_reg, dvd_next;
    logic [23:0] quo_reg, quo_next;
    logic [56:0] prod_reg, prod_next;

    logic        done_reg, done_next;
    logic [TW-1:0] out_reg, out_next;

    // memory ports
    logic              wct_we, ct_we, dt_we, tt_we, pw_we;
    logic [WCT_AW-1:0] wct_addr;
    logic [CT_AW-1:0]  ct_addr;
    logic [DT_AW-1:0]  dt_addr;
    logic [TOK_AW-1:0] tt_addr;
    logic [TW-1:0]     pw_addr;
    logic [CW-1:0]     wct_wd, ct_wd, dt_wd;
    logic [CW-1:0]     wct_rd, ct_rd, dt_rd;
    logic [TW-1:0]     tt_rd;
    logic [31:0]       pw_wd, pw_rd;

    logic [TW-1:0] zsel;
    logic [KW-1:0] k_eff;
    logic [32:0]   num_c;
    logic [35:0]   den_c;
    logic [32:0]   dsm_c;
    logic [36:0]   r1, r2;
    logic [35:0]   r1s, r2s;
    logic          b1, b2;
    logic [31:0]   w_c;
    logic [32:0]   acc_sum;
    logic [47:0]   tgt_prod;
    logic [16+KW-1:0] init_prod;
    logic          is_clear, is_dec_wr, is_inc_wr;

    lgts_ram #(.WIDTH(CW), .DEPTH(WCT_D)) u_wct_ram (
        .clk(clk), .we(wct_we), .addr(wct_addr), .wdata(wct_wd), .rdata(wct_rd));
    lgts_ram #(.WIDTH(CW), .DEPTH(CT_D)) u_ct_ram (
        .clk(clk), .we(ct_we), .addr(ct_addr), .wdata(ct_wd), .rdata(ct_rd));
    lgts_ram #(.WIDTH(CW), .DEPTH(DT_D)) u_dt_ram (
        .clk(clk), .we(dt_we), .addr(dt_addr), .wdata(dt_wd), .rdata(dt_rd));
    lgts_ram #(.WIDTH(TW), .DEPTH(MAX_TOKENS)) u_tt_ram (
        .clk(clk), .we(tt_we), .addr(tt_addr), .wdata(topic_reg), .rdata(tt_rd));
    lgts_ram #(.WIDTH(32), .DEPTH(MAX_TOPICS)) u_pw_ram (
        .clk(clk), .we(pw_we), .addr(pw_addr), .wdata(pw_wd), .rdata(pw_rd));

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign topic     = lgts_pkg::TOPIC_OUT_W'(out_reg);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_topics_reg <= lgts_pkg::RST_NUM_TOPICS;
            vocab_size_reg <= lgts_pkg::RST_VOCAB_SIZE;
            alpha_reg      <= lgts_pkg::RST_ALPHA;
            beta_reg       <= lgts_pkg::RST_BETA;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lgts_pkg::REG_NUM_TOPICS: num_topics_reg <= cfg_data[5:0];
                lgts_pkg::REG_VOCAB_SIZE: vocab_size_reg <= cfg_data[10:0];
                lgts_pkg::REG_ALPHA:      alpha_reg      <= cfg_data;
                lgts_pkg::REG_BETA:       beta_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // K clamped to 1..MAX_TOPICS
    always_comb
    begin
        if (num_topics_reg == 6'd0)
            k_eff = KW'(1);
        else if (32'(num_topics_reg) > 32'(MAX_TOPICS))
            k_eff = KW'(MAX_TOPICS);
        else
            k_eff = KW'(num_topics_reg);
    end

    assign is_clear  = (state_reg == S_CLEAR);
    assign is_dec_wr = (state_reg == S_DWR);
    assign is_inc_wr = (state_reg == S_IWR);

    always_comb
    begin
        case (state_reg) inside
            S_DRD:         zsel = tt_rd;
            S_DWR:         zsel = old_reg;
            S_IRD, S_IWR:  zsel = topic_reg;
            default:       zsel = TW'(z_reg);
        endcase
    end

    // count memory ports
    always_comb
    begin
        if (is_clear)
        begin
            wct_addr = WCT_AW'(clr_reg);
            ct_addr  = CT_AW'(clr_reg);
            dt_addr  = DT_AW'(clr_reg);
            wct_we   = (32'(clr_reg) < WCT_D);
            ct_we    = (32'(clr_reg) < CT_D);
            dt_we    = (32'(clr_reg) < DT_D);
            wct_wd   = '0;
            ct_wd    = '0;
            dt_wd    = '0;
        end
        else
        begin
            wct_addr = WCT_AW'(wbase_reg + WCT_AW'(zsel));
            ct_addr  = CT_AW'(cbase_reg + CT_AW'(zsel));
            dt_addr  = DT_AW'(dbase_reg + DT_AW'(zsel));
            wct_we   = is_dec_wr || is_inc_wr;
            ct_we    = is_dec_wr || is_inc_wr;
            dt_we    = is_dec_wr || is_inc_wr;
            if (is_dec_wr)
            begin
                wct_wd = (wct_rd == '0) ? '0 : wct_rd - 1'b1;
                ct_wd  = (ct_rd == '0) ? '0 : ct_rd - 1'b1;
                dt_wd  = (dt_rd == '0) ? '0 : dt_rd - 1'b1;
            end
            else
            begin
                wct_wd = (wct_rd == '1) ? '1 : wct_rd + 1'b1;
                ct_wd  = (ct_rd == '1) ? '1 : ct_rd + 1'b1;
                dt_wd  = (dt_rd == '1) ? '1 : dt_rd + 1'b1;
            end
        end
    end

    assign tt_addr = TOK_AW'(tok_reg);
    assign tt_we   = (state_reg == S_IRD);
    assign pw_we   = (state_reg == S_ACC);
    assign pw_addr = (state_reg == S_SCMP) ? TW'(z_reg + 1'b1) : TW'(z_reg);
    assign pw_wd   = acc_next;

    // per-topic arithmetic
    assign num_c = {1'b0, wct_rd, 16'h0} + 33'(beta_reg);
    assign den_c = {4'h0, ct_rd, 16'h0} + 36'(bw_reg);
    assign dsm_c = {1'b0, dt_rd, 16'h0} + 33'(alpha_reg);

    // two restoring divide steps per cycle
    always_comb
    begin
        r1  = {rem_reg, dvd_reg[23]};
        b1  = (r1 >= {1'b0, den_reg});
        r1s = b1 ? 36'(r1 - {1'b0, den_reg}) : r1[35:0];
        r2  = {r1s, dvd_reg[22]};
        b2  = (r2 >= {1'b0, den_reg});
        r2s = b2 ? 36'(r2 - {1'b0, den_reg}) : r2[35:0];
    end

    assign w_c       = (prod_reg[56:48] != '0) ? 32'hFFFF_FFFF : prod_reg[47:16];
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, w_c};
    assign tgt_prod  = r_reg * acc_reg;
    assign init_prod = r_reg * k_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        act_next   = act_reg;
        tok_next   = tok_reg;
        doc_next   = doc_reg;
        cls_next   = cls_reg;
        term_next  = term_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        bw_next    = bw_reg;
        step_next  = step_reg;
        wbase_next = wbase_reg;
        cbase_next = cbase_reg;
        dbase_next = dbase_reg;
        old_next   = old_reg;
        topic_next = topic_reg;
        z_next     = z_reg;
        acc_next   = acc_reg;
        tgt_next   = tgt_reg;
        den_next   = den_reg;
        dsm_next   = dsm_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        out_next   = out_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CLR_D - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    tok_next   = token_index;
                    doc_next   = 16'(doc_index);
                    cls_next   = 16'(class_index);
                    term_next  = 16'(term_id);
                    r_next     = random_value;
                    k_next     = k_eff;
                    bw_next    = beta_reg * vocab_size_reg;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                // index wrap by constant reciprocal
                tok_next  = lgts_pkg::mod_const(tok_reg, MAX_TOKENS);
                doc_next  = lgts_pkg::mod_const(doc_reg, MAX_DOCS);
                cls_next  = lgts_pkg::mod_const(cls_reg, MAX_CLASSES);
                term_next = lgts_pkg::mod_const(term_reg, MAX_VOCAB);
                wbase_next = WCT_AW'((32'(term_next) * MAX_CLASSES + 32'(cls_next))
                                     * MAX_TOPICS);
                cbase_next = CT_AW'(32'(cls_next) * MAX_TOPICS);
                dbase_next = DT_AW'(32'(doc_next) * MAX_TOPICS);
                if (act_reg)
                    state_next = S_TRD;
                else
                begin
                    topic_next = TW'(init_prod >> 16);
                    state_next = S_IRD;
                end
            end
            S_TRD:
                state_next = S_DRD;
            S_DRD:
            begin
                old_next   = tt_rd;
                state_next = S_DWR;
            end
            S_DWR:
            begin
                z_next     = '0;
                acc_next   = '0;
                state_next = S_LRD;
            end
            S_LRD:
                state_next = S_LCALC;
            S_LCALC:
            begin
                den_next = den_c;
                dsm_next = dsm_c;
                if (den_c == '0)
                begin
                    quo_next   = '0;
                    state_next = S_MUL;
                end
                else if ({11'h0, num_c} >= {den_c, 8'h0})
                begin
                    quo_next   = 24'hFF_FFFF;
                    state_next = S_MUL;
                end
                else
                begin
                    rem_next   = 36'(num_c >> 8);
                    dvd_next   = {num_c[7:0], 16'h0};
                    quo_next   = '0;
                    step_next  = 4'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = r2s;
                dvd_next  = {dvd_reg[21:0], 2'b00};
                quo_next  = {quo_reg[21:0], b1, b2};
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd11)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = quo_reg * dsm_reg;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                z_next   = z_reg + 1'b1;
                if (z_next == k_reg)
                    state_next = S_TGT;
                else
                    state_next = S_LRD;
            end
            S_TGT:
            begin
                tgt_next   = tgt_prod[47:16];
                z_next     = '0;
                state_next = S_SRD;
            end
            S_SRD:
                state_next = S_SCMP;
            S_SCMP:
            begin
                if (pw_rd > tgt_reg)
                begin
                    topic_next = TW'(z_reg);
                    state_next = S_IRD;
                end
                else if (z_reg + 1'b1 == k_reg)
                begin
                    topic_next = old_reg;
                    state_next = S_IRD;
                end
                else
                    z_next = z_reg + 1'b1;
            end
            S_IRD:
                state_next = S_IWR;
            S_IWR:
            begin
                done_next  = 1'b1;
                out_next   = topic_reg;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        tok_reg   <= tok_next;
        doc_reg   <= doc_next;
        cls_reg   <= cls_next;
        term_reg  <= term_next;
        r_reg     <= r_next;
        k_reg     <= k_next;
        bw_reg    <= bw_next;
        step_reg  <= step_next;
        wbase_reg <= wbase_next;
        cbase_reg <= cbase_next;
        dbase_reg <= dbase_next;
        old_reg   <= old_next;
        topic_reg <= topic_next;
        z_reg     <= z_next;
        acc_reg   <= acc_next;
        tgt_reg   <= tgt_next;
        den_reg   <= den_next;
        dsm_reg   <= dsm_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

endmodule
`default_nettype wire

/* tb/tb_labeled_lda_gibbs_topic_sampler_core.sv */
// Self-checking testbench for labeled_lda_gibbs_topic_sampler_core: directed items, then
// random init/resample items over several register settings, checked against a local predictor.
// Depends on lgts_pkg and the sampler RTL.
module tb_labeled_lda_gibbs_topic_sampler_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_INIT     = 1'b0;
    localparam logic ACT_RESAMPLE = 1'b1;
    localparam int   CYCLE_LIMIT  = 3_000_000;
    // key offsets of the three count stores in one sparse array
    localparam int   CLS_OFS = 1 << 20;
    localparam int   DOC_OFS = 2 << 20;

    typedef struct {
        logic        act;
        logic [15:0] tok;
        logic [9:0]  doc;
        logic [2:0]  cls;
        logic [9:0]  term;
        logic [15:0] r;
        bit          typed;
        logic [4:0]  want;
    } item_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [15:0] token_index;
    logic [9:0]  doc_index;
    logic [2:0]  class_index;
    logic [9:0]  term_id;
    logic [15:0] random_value;
    logic        done;
    logic [4:0]  topic;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    // predictor state
    logic [15:0] topic_counts[int];
    logic [4:0]  token_topics[int];
    logic [15:0] live_tokens[$];
    logic [5:0]  k_reg;
    logic [10:0] w_reg;
    logic [23:0] alpha_reg;
    logic [23:0] beta_reg;

    logic [4:0]  topic_fifo[$];
    int          mismatches;
    int          cycles;
    int          idle_pct;

    labeled_lda_gibbs_topic_sampler_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .token_index(token_index), .doc_index(doc_index), .class_index(class_index),
        .term_id(term_id), .random_value(random_value), .done(done), .topic(topic),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [15:0] count_of(input int key);
        if (topic_counts.exists(key))
            return topic_counts[key];
        return 16'd0;
    endfunction

    function automatic void bump(input int wkey, input int ckey, input int dkey, input bit up);
        int keys[3];
        logic [15:0] c;
        keys = '{wkey, ckey, dkey};
        foreach (keys[i])
        begin
            c = count_of(keys[i]);
            if (up && c != 16'hFFFF)
                topic_counts[keys[i]] = c + 16'd1;
            else if (!up && c != 16'd0)
                topic_counts[keys[i]] = c - 16'd1;
        end
    endfunction

    function automatic logic [4:0] gibbs_pick(input item_row_t it);
        int k, wb, cb, db, z, pick;
        logic [63:0] acc, target, num, den, dsm, ratio, w;
        logic [31:0] prefix[32];
        k  = (k_reg == 0) ? 1 : ((k_reg > 32) ? 32 : int'(k_reg));
        wb = (int'(it.term) * 8 + int'(it.cls)) * 32;
        cb = CLS_OFS + int'(it.cls) * 32;
        db = DOC_OFS + int'(it.doc) * 32;
        if (it.act == ACT_INIT)
            pick = int'((64'(it.r) * 64'(k)) >> 16);
        else
        begin
            pick = token_topics.exists(it.tok) ? int'(token_topics[it.tok]) : 0;
            bump(wb + pick, cb + pick, db + pick, 1'b0);
            acc = 0;
            for (z = 0; z < k; z++)
            begin
                num = (64'(count_of(wb + z)) << 16) + 64'(beta_reg);
                den = (64'(count_of(cb + z)) << 16) + 64'(beta_reg) * 64'(w_reg);
                dsm = (64'(count_of(db + z)) << 16) + 64'(alpha_reg);
                ratio = 0;
                if (den != 0)
                begin
                    ratio = (num << 16) / den;
                    if (ratio > 64'hFFFFFF)
                        ratio = 64'hFFFFFF;
                end
                w = (ratio * dsm) >> 16;
                if (w > 64'hFFFFFFFF)
                    w = 64'hFFFFFFFF;
                acc += w;
                if (acc > 64'hFFFFFFFF)
                    acc = 64'hFFFFFFFF;
                prefix[z] = acc[31:0];
            end
            target = (64'(it.r) * acc) >> 16;
            for (z = 0; z < k; z++)
                if (64'(prefix[z]) > target)
                begin
                    pick = z;
                    break;
                end
        end
        token_topics[it.tok] = 5'(pick);
        bump(wb + pick, cb + pick, db + pick, 1'b1);
        return 5'(pick);
    endfunction

    // leaves start high unless it adds a random idle gap; the caller lowers it or sends again in the same step
    task automatic send_item(input item_row_t it);
        logic [4:0] p;
        action       <= it.act;
        token_index  <= it.tok;
        doc_index    <= it.doc;
        class_index  <= it.cls;
        term_id      <= it.term;
        random_value <= it.r;
        start        <= 1'b1;
        do @(posedge clk); while (busy);
        p = gibbs_pick(it);
        topic_fifo.push_back(it.typed ? it.want : p);
        if (it.act == ACT_INIT)
            live_tokens.push_back(it.tok);
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (topic_fifo.size() != 0 || busy)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_regs(input logic [5:0] k, input logic [10:0] w,
                              input logic [23:0] a, input logic [23:0] b);
        logic [23:0] vals[4];
        vals = '{24'(k), 24'(w), a, b};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            case (2'(i))
                lgts_pkg::REG_NUM_TOPICS: k_reg     = vals[i][5:0];
                lgts_pkg::REG_VOCAB_SIZE: w_reg     = vals[i][10:0];
                lgts_pkg::REG_ALPHA:      alpha_reg = vals[i];
                lgts_pkg::REG_BETA:       beta_reg  = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic item_row_t random_item();
        item_row_t it;
        bit narrow;
        narrow  = $urandom_range(0, 99) < 75;
        it.typed = 1'b0;
        it.want  = '0;
        it.r     = 16'($urandom);
        it.cls   = 3'($urandom);
        it.doc   = narrow ? 10'($urandom_range(0, 7)) : 10'($urandom);
        it.term  = narrow ? 10'($urandom_range(0, 15)) : 10'($urandom);
        if (live_tokens.size() == 0 || $urandom_range(0, 99) < 35)
        begin
            it.act = ACT_INIT;
            it.tok = narrow ? 16'($urandom_range(0, 255)) : 16'($urandom);
        end
        else
        begin
            it.act = ACT_RESAMPLE;
            it.tok = live_tokens[$urandom_range(0, live_tokens.size() - 1)];
        end
        return it;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (topic_fifo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result topic=%0d", topic);
            end
            else if (topic !== topic_fifo[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("topic mismatch: expected %0d got %0d", topic_fifo[0], topic);
                void'(topic_fifo.pop_front());
            end
            else
                void'(topic_fifo.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL labeled_lda_gibbs_topic_sampler_core");
            $finish;
        end
    end

    initial
    begin
        item_row_t dir_tab[] = '{
            '{ACT_INIT,     16'h0000, 10'h000, 3'd0, 10'h000, 16'h0000, 1, 5'd0},
            '{ACT_INIT,     16'hFFFF, 10'h3FF, 3'd7, 10'h3FF, 16'hFFFF, 1, 5'd7},
            '{ACT_INIT,     16'h0001, 10'h000, 3'd0, 10'h000, 16'h8000, 1, 5'd4},
            '{ACT_INIT,     16'h0002, 10'h000, 3'd0, 10'h000, 16'h2000, 1, 5'd1},
            '{ACT_INIT,     16'h5555, 10'h2AA, 3'd5, 10'h155, 16'hAAAA, 1, 5'd5},
            '{ACT_RESAMPLE, 16'h0000, 10'h000, 3'd0, 10'h000, 16'h0000, 0, 5'd0},
            '{ACT_RESAMPLE, 16'hFFFF, 10'h3FF, 3'd7, 10'h3FF, 16'hFFFF, 0, 5'd0},
            '{ACT_INIT,     16'h0001, 10'h000, 3'd0, 10'h000, 16'hFFFF, 1, 5'd7},
            '{ACT_RESAMPLE, 16'h0001, 10'h000, 3'd0, 10'h000, 16'h4000, 0, 5'd0},
            '{ACT_RESAMPLE, 16'h0002, 10'h000, 3'd0, 10'h000, 16'hFFFF, 0, 5'd0},
            '{ACT_RESAMPLE, 16'h5555, 10'h2AA, 3'd5, 10'h155, 16'h8000, 0, 5'd0}
        };
        // {num_topics, vocab_size, alpha, beta} per phase
        logic [64:0] settings[] = '{
            {6'd1,  11'd1,    24'd0,       24'd0},
            {6'd32, 11'd1024, 24'hFFFFFF,  24'hFFFFFF},
            {6'd4,  11'd100,  24'd32768,   24'd6554},
            {6'd0,  11'd2047, 24'd0,       24'd65536},
            {6'd63, 11'd0,    24'd1000,    24'd0},
            {6'd6,  11'd512,  24'd0,       24'd0},
            {6'd12, 11'd1023, 24'd100000,  24'd300}
        };
        int n_per;
        mismatches = 0;
        cycles     = 0;
        idle_pct   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        action       = ACT_INIT;
        token_index  = '0;
        doc_index    = '0;
        class_index  = '0;
        term_id      = '0;
        random_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = lgts_pkg::REG_NUM_TOPICS;
        cfg_data     = '0;
        k_reg     = lgts_pkg::RST_NUM_TOPICS;
        w_reg     = lgts_pkg::RST_VOCAB_SIZE;
        alpha_reg = lgts_pkg::RST_ALPHA;
        beta_reg  = lgts_pkg::RST_BETA;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_item(dir_tab[i]);
        drain();

        // single topic: every init lands on topic 0
        write_regs(6'd1, 11'd1024, 24'd32768, 24'd6554);
        send_item('{ACT_INIT, 16'h0100, 10'h001, 3'd1, 10'h001, 16'hFFFF, 1, 5'd0});
        send_item('{ACT_RESAMPLE, 16'h0100, 10'h001, 3'd1, 10'h001, 16'h7FFF, 1, 5'd0});
        drain();

        n_per = 850 / settings.size();
        foreach (settings[p])
        begin
            write_regs(settings[p][64:59], settings[p][58:48], settings[p][47:24],
                       settings[p][23:0]);
            for (int i = 0; i < n_per; i++)
            begin
                idle_pct = (i < n_per / 3) ? 0 : ((i < 2 * n_per / 3) ? 58 : 12);
                if (p == 1 && i == n_per / 2)
                begin
                    start <= 1'b0;
                    while (topic_fifo.size() != 0)
                        @(posedge clk);
                end
                send_item(random_item());
            end
            drain();
        end

        if (mismatches == 0 && topic_fifo.size() == 0)
            $display("PASS labeled_lda_gibbs_topic_sampler_core");
        else
            $display("FAIL labeled_lda_gibbs_topic_sampler_core");
        $finish;
    end
endmodule

/* sim.f */
hdl/lgts_pkg.sv
hdl/lgts_ram.sv
hdl/labeled_lda_gibbs_topic_sampler_core.sv
tb/tb_labeled_lda_gibbs_topic_sampler_core.sv
